// ===== rtl/bbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types and constants of the beacon biphase demodulator.
// ----------------------------------------------------------------------------
package bbd_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int AVG_W       = 17;
    localparam int Y_W         = 25;
    localparam int TAP_W       = 26;
    localparam int FRAME_MAX   = 120;
    localparam int HB_W        = 8;
    localparam int SYNC_W      = 22;
    localparam int THR_W       = 15;
    localparam int PHASE_CFG_W = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 22;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 152;

    localparam logic [THR_W-1:0]       RST_SLICE_THRESHOLD = 15'd614;
    localparam logic [PHASE_CFG_W-1:0] RST_SAMPLE_PHASE    = 5'd7;
    localparam logic [SYNC_W-1:0]      RST_SYNC_NORMAL     = 22'h2959AA;
    localparam logic [SYNC_W-1:0]      RST_SYNC_ALTERNATE  = 22'h29A655;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLICE_THRESHOLD = 2'd0,
        CFG_SAMPLE_PHASE    = 2'd1,
        CFG_SYNC_NORMAL     = 2'd2,
        CFG_SYNC_ALTERNATE  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic en;
        logic vld;
    } t_stage_ctl;

    typedef struct packed {
        logic                    vld;
        logic signed [AVG_W-1:0] avg;
    } t_avg;

endpackage

// ===== rtl/beacon_biphase_demodulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_biphase_demodulator
// Demodulates biphase beacon audio into 120-bit frames.
// ----------------------------------------------------------------------------
// Takes one audio sample per clock while the output is not held, and returns
// one result per sample. The moving-average ring sits in a memory whose
// registered read is issued at the accepting edge. After that the sample
// passes the running sum register, the reciprocal multiply that divides by
// the tap count, the DC blocker register and the slicer, clock recovery and
// frame assembler, whose result lands in the output register. A result held
// by the receiver freezes the whole pipeline and holds off the input. The
// ring has a valid bit per entry, so no clearing pass follows reset.
module beacon_biphase_demodulator
    import bbd_pkg::*;
#(
    parameter int AVERAGE_TAPS     = 10,
    parameter int HALF_BIT_SAMPLES = 20,
    parameter int FRAME_BITS       = 120
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [15:0] audio_sample
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [24:0] filtered_sample, [88:25] frame_low, [144:89] frame_high, rest zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [0] sliced_level, [1] sync_found, [2] frame_valid, [3] frame_alternate
    output logic [3:0]             o_m_axis_tuser,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int PHW  = $clog2(HALF_BIT_SAMPLES + 2);
    localparam int CMPW = (PHW > PHASE_CFG_W) ? PHW : PHASE_CFG_W;

    typedef enum logic [1:0] {
        TRIM_NONE,
        TRIM_FAST,
        TRIM_SLOW
    } t_trim;

    typedef struct packed {
        logic frame_alternate;
        logic frame_valid;
        logic sync_found;
        logic sliced_level;
    } t_flags;

    logic [THR_W-1:0]       r_thr;
    logic [PHASE_CFG_W-1:0] r_sample_phase;
    logic [SYNC_W-1:0]      r_sync_norm;
    logic [SYNC_W-1:0]      r_sync_alt;

    logic       en;
    t_stage_ctl avg_ctl;
    t_avg       avg;

    logic signed [TAP_W-1:0] r_tap;
    logic signed [TAP_W-1:0] n_tap;
    logic signed [Y_W-1:0]   n_y;
    logic signed [Y_W+1:0]   y_full;
    logic signed [TAP_W:0]   tap_full;
    logic                    r_e_vld;
    logic signed [Y_W-1:0]   r_e_y;

    logic                  r_slice;
    logic                  n_slice;
    logic                  edge_hit;
    t_trim                 r_trim;
    t_trim                 n_trim;
    logic [PHW-1:0]        r_phase;
    logic [PHW-1:0]        n_phase;
    logic [PHW-1:0]        ph_inc;
    logic                  wrap;
    logic                  take;
    logic [SYNC_W-1:0]     r_hist;
    logic [SYNC_W-1:0]     n_hist;
    logic                  r_recv;
    logic                  n_recv;
    logic [HB_W-1:0]       r_hb;
    logic [HB_W-1:0]       n_hb;
    logic [FRAME_BITS-1:0] r_frame;
    logic [FRAME_BITS-1:0] n_frame;
    logic                  r_alt;
    logic                  n_alt;
    logic                  f_sync;
    logic                  f_done;
    logic signed [Y_W-1:0] thr_pos;

    logic                  r_out_vld;
    logic signed [Y_W-1:0] r_out_y;
    logic [FRAME_MAX-1:0]  r_out_frame;
    t_flags                r_out_flags;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr          <= RST_SLICE_THRESHOLD;
            r_sample_phase <= RST_SAMPLE_PHASE;
            r_sync_norm    <= RST_SYNC_NORMAL;
            r_sync_alt     <= RST_SYNC_ALTERNATE;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SLICE_THRESHOLD: r_thr          <= i_cfg_data[THR_W-1:0];
                CFG_SAMPLE_PHASE:    r_sample_phase <= i_cfg_data[PHASE_CFG_W-1:0];
                CFG_SYNC_NORMAL:     r_sync_norm    <= i_cfg_data[SYNC_W-1:0];
                CFG_SYNC_ALTERNATE:  r_sync_alt     <= i_cfg_data[SYNC_W-1:0];
            endcase
        end
    end

    // pipeline advances whenever the output slot is free or being taken
    assign en              = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign avg_ctl.en      = en;
    assign avg_ctl.vld     = i_s_axis_tvalid;

    bbd_avg #(
        .AVERAGE_TAPS (AVERAGE_TAPS)
    ) u_avg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (avg_ctl),
        .i_sample ($signed(i_s_axis_tdata[SAMPLE_W-1:0])),
        .o_avg    (avg)
    );

    // dc blocker
    always_comb begin
        y_full = {{(Y_W+2-AVG_W-8){avg.avg[AVG_W-1]}}, avg.avg, 8'b0}
                 + {r_tap[TAP_W-1], r_tap};
        if (y_full[Y_W+1:Y_W-1] == 3'b000 || y_full[Y_W+1:Y_W-1] == 3'b111) begin
            n_y = y_full[Y_W-1:0];
        end else if (y_full[Y_W+1]) begin
            n_y = {1'b1, {(Y_W-1){1'b0}}};
        end else begin
            n_y = {1'b0, {(Y_W-1){1'b1}}};
        end
        tap_full = {r_tap[TAP_W-1], r_tap}
                   - {{(TAP_W+9-Y_W){n_y[Y_W-1]}}, n_y[Y_W-1:8]};
        if (tap_full[TAP_W] == tap_full[TAP_W-1]) begin
            n_tap = tap_full[TAP_W-1:0];
        end else if (tap_full[TAP_W]) begin
            n_tap = {1'b1, {(TAP_W-1){1'b0}}};
        end else begin
            n_tap = {1'b0, {(TAP_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap   <= '0;
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= avg.vld;
            if (avg.vld) begin
                r_tap <= n_tap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && avg.vld) begin
            r_e_y <= n_y;
        end
    end

    // slicer, half-bit clock, sync search and frame assembly
    assign thr_pos = {2'b00, r_thr, 8'b0};

    always_comb begin
        n_slice  = r_slice;
        edge_hit = 1'b0;
        if (!r_slice && r_e_y > thr_pos) begin
            n_slice  = 1'b1;
            edge_hit = 1'b1;
        end else if (r_slice && r_e_y < -thr_pos) begin
            n_slice  = 1'b0;
            edge_hit = 1'b1;
        end

        n_trim = r_trim;
        if (edge_hit && r_phase >= PHW'(HALF_BIT_SAMPLES / 2)
                && r_phase < PHW'(HALF_BIT_SAMPLES - 1)) begin
            n_trim = TRIM_FAST;
        end
        if (edge_hit && r_phase < PHW'(HALF_BIT_SAMPLES / 2) && r_phase > PHW'(1)) begin
            n_trim = TRIM_SLOW;
        end

        ph_inc = r_phase + 1'b1;
        unique case (n_trim)
            TRIM_FAST: wrap = ph_inc >= PHW'(HALF_BIT_SAMPLES - 1);
            TRIM_SLOW: wrap = ph_inc >= PHW'(HALF_BIT_SAMPLES + 1);
            default:   wrap = ph_inc >= PHW'(HALF_BIT_SAMPLES);
        endcase
        n_phase = wrap ? '0 : ph_inc;
        take    = CMPW'(n_phase) == CMPW'(r_sample_phase);

        n_hist  = r_hist;
        n_recv  = r_recv;
        n_hb    = r_hb;
        n_frame = r_frame;
        n_alt   = r_alt;
        f_sync  = 1'b0;
        f_done  = 1'b0;
        if (take) begin
            if (r_recv) begin
                n_hb = r_hb + 1'b1;
                if (n_hb[0]) begin
                    n_frame = {r_frame[FRAME_BITS-2:0], n_slice};
                end
                if (n_hb >= HB_W'(2 * FRAME_BITS)) begin
                    n_recv = 1'b0;
                    n_hb   = '0;
                    f_done = 1'b1;
                end
            end else begin
                n_hist = {r_hist[SYNC_W-2:0], n_slice};
                if (n_hist == r_sync_norm) begin
                    f_sync = 1'b1;
                    n_alt  = 1'b0;
                end
                if (n_hist == r_sync_alt) begin
                    f_sync = 1'b1;
                    n_alt  = 1'b1;
                end
                if (f_sync) begin
                    n_recv  = 1'b1;
                    n_hb    = '0;
                    n_frame = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice   <= 1'b0;
            r_trim    <= TRIM_NONE;
            r_phase   <= '0;
            r_hist    <= '0;
            r_recv    <= 1'b0;
            r_hb      <= '0;
            r_frame   <= '0;
            r_alt     <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_e_vld;
            if (r_e_vld) begin
                r_slice <= n_slice;
                r_trim  <= n_trim;
                r_phase <= n_phase;
                r_hist  <= n_hist;
                r_recv  <= n_recv;
                r_hb    <= n_hb;
                r_frame <= n_frame;
                r_alt   <= n_alt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_e_vld) begin
            r_out_y                     <= r_e_y;
            r_out_frame                 <= f_done ? FRAME_MAX'(n_frame) : '0;
            r_out_flags.sliced_level    <= n_slice;
            r_out_flags.sync_found      <= f_sync;
            r_out_flags.frame_valid     <= f_done;
            r_out_flags.frame_alternate <= f_done & n_alt;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {(OUT_TDATA_W-FRAME_MAX-Y_W)'(0), r_out_frame, r_out_y};
    assign o_m_axis_tuser  = r_out_flags;

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PHW'(HALF_BIT_SAMPLES))
        else $error("half-bit clock phase out of range");

    a_sync_or_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out_flags.sync_found && r_out_flags.frame_valid))
        else $error("sync and frame delivery on one sample");

    a_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_flags.frame_valid) |->
            (r_out_frame == '0 && !r_out_flags.frame_alternate))
        else $error("frame bits set without a delivered frame");

    a_hb_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_recv |-> (r_hb < HB_W'(2 * FRAME_BITS)))
        else $error("half-bit count past frame end");

    a_hist_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_recv) && r_recv) |-> $stable(r_hist))
        else $error("sync history moved during a frame");

endmodule

// ===== rtl/bbd_avg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_avg
// Moving average over a ring held in a synchronous memory, running sum,
// division by the tap count through a reciprocal multiply.
// ----------------------------------------------------------------------------
module bbd_avg
    import bbd_pkg::*;
#(
    parameter int AVERAGE_TAPS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_stage_ctl                 i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output t_avg                       o_avg
);

    localparam int CL    = $clog2(AVERAGE_TAPS);
    localparam int PW    = (AVERAGE_TAPS > 1) ? CL : 1;
    localparam int MW    = SAMPLE_W + CL;
    localparam int SW    = MW + 1;
    localparam int K     = MW + CL;
    localparam logic [MW:0] RECIP =
        (MW+1)'(((longint'(1) << K) + longint'(AVERAGE_TAPS) - 1) / longint'(AVERAGE_TAPS));

    logic signed [SAMPLE_W-1:0] r_mem [AVERAGE_TAPS];
    logic [AVERAGE_TAPS-1:0]    r_ok;
    logic [PW-1:0]              r_pos;
    logic [PW-1:0]              n_pos;
    logic signed [SW-1:0]       r_sum;
    logic signed [SW-1:0]       n_sum;

    logic                       r_b_vld;
    logic [PW-1:0]              r_b_addr;
    logic signed [SAMPLE_W-1:0] r_b_samp;
    logic signed [SAMPLE_W-1:0] r_rd;
    logic                       r_rd_ok;
    logic                       r_fwd;
    logic signed [SAMPLE_W-1:0] r_fwd_data;
    logic signed [SAMPLE_W-1:0] old_samp;
    logic                       fwd_hit;

    logic                       r_c_vld;
    logic signed [SW-1:0]       r_c_sum;
    logic [MW-1:0]              mag;

    logic                       r_d_vld;
    logic [2*MW:0]              r_d_prod;
    logic                       r_d_neg;
    logic [AVG_W-1:0]           quot;

    assign n_pos   = (r_pos == PW'(AVERAGE_TAPS - 1)) ? '0 : r_pos + 1'b1;
    assign fwd_hit = r_b_vld && (r_b_addr == r_pos);

    always_comb begin
        if (r_fwd) begin
            old_samp = r_fwd_data;
        end else if (r_rd_ok) begin
            old_samp = r_rd;
        end else begin
            old_samp = '0;
        end
        n_sum = r_sum + SW'(r_b_samp) - SW'(old_samp);
    end

    assign mag  = r_c_sum[SW-1] ? MW'(-r_c_sum) : MW'(r_c_sum);
    assign quot = r_d_prod[K+AVG_W-1:K];

    assign o_avg.vld = r_d_vld;
    assign o_avg.avg = r_d_neg ? -$signed(quot) : $signed(quot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_ok    <= '0;
            r_sum   <= '0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_b_vld <= i_ctl.vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            if (i_ctl.vld) begin
                r_pos <= n_pos;
            end
            if (r_b_vld) begin
                r_ok[r_b_addr] <= 1'b1;
                r_sum          <= n_sum;
            end
        end
    end

    // ring memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.vld) begin
                r_rd <= r_mem[r_pos];
            end
            if (r_b_vld) begin
                r_mem[r_b_addr] <= r_b_samp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.vld) begin
                r_b_addr   <= r_pos;
                r_b_samp   <= i_sample;
                r_rd_ok    <= r_ok[r_pos] | fwd_hit;
                r_fwd      <= fwd_hit;
                r_fwd_data <= r_b_samp;
            end
            if (r_b_vld) begin
                r_c_sum <= n_sum;
            end
            if (r_c_vld) begin
                r_d_prod <= mag * RECIP;
                r_d_neg  <= r_c_sum[SW-1];
            end
        end
    end

endmodule

// ===== bench/beacon_biphase_demodulator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_biphase_demodulator_test
// Self-checking bench for the biphase beacon demodulator.
// ----------------------------------------------------------------------------
// Audio samples go in over the slave stream with random gaps, and results are
// taken from the master stream with random stalls and one long hold-off. A
// behavioral demodulator in this file runs on each accepted sample and keeps
// the expected results in order. Every result is checked field by field.
// The stimulus is a short directed set with noise, then a beacon burst
// (preamble, sync word, payload) under new register settings, then noise
// under extreme settings.
module beacon_biphase_demodulator_test
    import bbd_pkg::*;
();

    localparam int AVG_TAPS        = 10;
    localparam int HALF_BIT        = 20;
    localparam int FRAME_LEN       = 120;
    localparam int CYCLE_LIMIT     = 100000;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct {
        logic [Y_W-1:0] filtered;
        logic           level;
        logic           sync_hit;
        logic           frame_done;
        logic           frame_alt;
        logic [63:0]    frame_lo;
        logic [55:0]    frame_hi;
    } t_demod_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [3:0]             o_m_axis_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // register copies
    logic [THR_W-1:0]       thr_reg = RST_SLICE_THRESHOLD;
    logic [PHASE_CFG_W-1:0] phase_reg = RST_SAMPLE_PHASE;
    logic [SYNC_W-1:0]      sync_normal_reg = RST_SYNC_NORMAL;
    logic [SYNC_W-1:0]      sync_alt_reg = RST_SYNC_ALTERNATE;

    // demodulator state
    longint      avg_ring [AVG_TAPS] = '{default: 0};
    longint      ring_sum = 0;
    int          ring_pos = 0;
    longint      dc_tap = 0;
    bit          slicer_q = 1'b0;
    int          phase_cnt = 0;
    int          phase_trim = 0;
    bit [21:0]   sync_shift = '0;
    bit          in_frame = 1'b0;
    bit [7:0]    halfbit_cnt = '0;
    bit [59:0]   frame_word [2] = '{default: '0};
    bit          alt_seen = 1'b0;

    logic [15:0]   audio_backlog [$];
    t_demod_result demod_outputs [$];
    t_demod_result want;

    int   fed_count = 0;
    int   error_count = 0;
    int   cycle_count = 0;
    int   tx_wait = 0;
    int   rx_wait = 0;
    bit   tx_calm = 1'b0;
    bit   rx_calm = 1'b0;
    logic hold_off = 1'b0;

    logic                   took_result = 1'b0;
    logic [OUT_TDATA_W-1:0] took_tdata = '0;
    logic [3:0]             took_tuser = '0;

    beacon_biphase_demodulator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // average, dc block, slice, recover the half-bit clock, assemble the frame
    function automatic void demodulate_sample(logic [15:0] raw);
        longint        s;
        longint        avg;
        longint        y;
        longint        thr;
        bit            edge_hit;
        int            ph;
        t_demod_result r;
        r = '{default: '0};
        s = longint'(signed'(raw));
        ring_sum = ring_sum + s - avg_ring[ring_pos];
        avg_ring[ring_pos] = s;
        ring_pos = (ring_pos + 1) % AVG_TAPS;
        avg = ring_sum / AVG_TAPS;

        y = clamp(avg * 256 + dc_tap, -64'sd16777216, 64'sd16777215);
        dc_tap = clamp(dc_tap - (y >>> 8), -64'sd33554432, 64'sd33554431);

        thr = longint'(thr_reg) * 256;
        edge_hit = 1'b0;
        if (!slicer_q && y > thr) begin
            edge_hit = 1'b1;
            slicer_q = 1'b1;
        end
        if (slicer_q && y < -thr) begin
            edge_hit = 1'b1;
            slicer_q = 1'b0;
        end

        ph = phase_cnt;
        if (edge_hit && ph >= HALF_BIT / 2 && ph < HALF_BIT - 1) phase_trim = 1;
        if (edge_hit && ph < HALF_BIT / 2 && ph > 1) phase_trim = -1;
        ph = ph + 1;
        if (ph + phase_trim >= HALF_BIT) ph = 0;
        phase_cnt = ph;

        if (ph == int'(phase_reg)) begin
            if (in_frame) begin
                halfbit_cnt = halfbit_cnt + 8'd1;
                if (halfbit_cnt[0]) begin
                    frame_word[1] = {frame_word[1][58:0], frame_word[0][59]};
                    frame_word[0] = {frame_word[0][58:0], slicer_q};
                end
                if (halfbit_cnt >= 2 * FRAME_LEN) begin
                    in_frame = 1'b0;
                    halfbit_cnt = '0;
                    r.frame_done = 1'b1;
                    r.frame_alt = alt_seen;
                    r.frame_lo = {frame_word[1][3:0], frame_word[0]};
                    r.frame_hi = frame_word[1][59:4];
                end
            end else begin
                sync_shift = {sync_shift[20:0], slicer_q};
                if (sync_shift == sync_normal_reg) begin
                    r.sync_hit = 1'b1;
                    alt_seen = 1'b0;
                end
                if (sync_shift == sync_alt_reg) begin
                    r.sync_hit = 1'b1;
                    alt_seen = 1'b1;
                end
                if (r.sync_hit) begin
                    in_frame = 1'b1;
                    halfbit_cnt = '0;
                    frame_word[0] = '0;
                    frame_word[1] = '0;
                end
            end
        end

        r.filtered = y[Y_W-1:0];
        r.level = slicer_q;
        demod_outputs.push_back(r);
    endfunction

    task automatic flag_error(string msg);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                demodulate_sample(i_s_axis_tdata);
                fed_count++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (audio_backlog.size() > 0) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= audio_backlog.pop_front();
                    if ($urandom_range(0, 499) == 0) tx_calm = !tx_calm;
                    tx_wait = tx_calm ? 0 : draw_gap();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            i_m_axis_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if ($urandom_range(0, 699) == 0) rx_calm = !rx_calm;
            rx_wait = rx_calm ? 0 : draw_gap();
        end
    end

    // result monitor, checks the transaction captured at the previous edge
    always @(posedge i_clk) begin
        if (took_result) begin
            if (demod_outputs.size() == 0) begin
                flag_error("result with no expectation");
            end else begin
                want = demod_outputs.pop_front();
                if (took_tdata[24:0] !== want.filtered)
                    flag_error($sformatf("filtered_sample got %h want %h",
                                         took_tdata[24:0], want.filtered));
                if (took_tuser[0] !== want.level)
                    flag_error($sformatf("sliced_level got %b want %b",
                                         took_tuser[0], want.level));
                if (took_tuser[1] !== want.sync_hit)
                    flag_error($sformatf("sync_found got %b want %b",
                                         took_tuser[1], want.sync_hit));
                if (took_tuser[2] !== want.frame_done)
                    flag_error($sformatf("frame_valid got %b want %b",
                                         took_tuser[2], want.frame_done));
                if (took_tuser[3] !== want.frame_alt)
                    flag_error($sformatf("frame_alternate got %b want %b",
                                         took_tuser[3], want.frame_alt));
                if (took_tdata[88:25] !== want.frame_lo)
                    flag_error($sformatf("frame_low got %h want %h",
                                         took_tdata[88:25], want.frame_lo));
                if (took_tdata[144:89] !== want.frame_hi)
                    flag_error($sformatf("frame_high got %h want %h",
                                         took_tdata[144:89], want.frame_hi));
                if (took_tdata[OUT_TDATA_W-1:145] !== '0)
                    flag_error($sformatf("tdata padding got %h",
                                         took_tdata[OUT_TDATA_W-1:145]));
            end
        end
        took_result <= i_rst_n && o_m_axis_tvalid && i_m_axis_tready;
        took_tdata <= o_m_axis_tdata;
        took_tuser <= o_m_axis_tuser;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // long receiver hold-off while samples keep coming
    initial begin
        do @(negedge i_clk); while (fed_count < 400);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (audio_backlog.size() != 0 || i_s_axis_tvalid ||
               demod_outputs.size() != 0 || took_result);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SLICE_THRESHOLD: thr_reg = val[THR_W-1:0];
            CFG_SAMPLE_PHASE:    phase_reg = val[PHASE_CFG_W-1:0];
            CFG_SYNC_NORMAL:     sync_normal_reg = val[SYNC_W-1:0];
            CFG_SYNC_ALTERNATE:  sync_alt_reg = val[SYNC_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    function automatic logic [SYNC_W-1:0] random_biphase_word();
        logic [SYNC_W-1:0] w;
        bit                b;
        w = '0;
        for (int k = 0; k < SYNC_W / 2; k++) begin
            b = $urandom_range(0, 1);
            w = {w[SYNC_W-3:0], b, !b};
        end
        return w;
    endfunction

    // preamble, sync word, random biphase payload and a short tail
    task automatic queue_burst(logic [SYNC_W-1:0] word, int pre_pairs, int payload_bits,
                               int hi, int lo, int jitter);
        bit halfbits [$];
        bit b;
        int v;
        repeat (pre_pairs) begin
            halfbits.push_back(1'b1);
            halfbits.push_back(1'b0);
        end
        for (int k = SYNC_W - 1; k >= 0; k--) halfbits.push_back(word[k]);
        repeat (payload_bits) begin
            b = $urandom_range(0, 1);
            halfbits.push_back(b);
            halfbits.push_back(!b);
        end
        repeat (2) begin
            halfbits.push_back(1'b1);
            halfbits.push_back(1'b0);
        end
        foreach (halfbits[k]) begin
            repeat (HALF_BIT) begin
                v = (halfbits[k] ? hi : lo) + int'($urandom_range(0, 2 * jitter)) - jitter;
                audio_backlog.push_back(16'(v));
            end
        end
    endtask

    task automatic queue_noise(int count);
        repeat (count) begin
            case ($urandom_range(0, 2))
                0: audio_backlog.push_back(16'($urandom));
                1: audio_backlog.push_back(16'(int'($urandom_range(0, 600)) - 300));
                default: audio_backlog.push_back($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
            endcase
        end
    endtask

    initial begin
        int                amp;
        logic [SYNC_W-1:0] word;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: field extremes, full-scale steps, then noise
        audio_backlog.push_back(16'h7FFF);
        audio_backlog.push_back(16'h8000);
        audio_backlog.push_back(16'h0000);
        audio_backlog.push_back(16'hFFFF);
        audio_backlog.push_back(16'h0001);
        audio_backlog.push_back(16'h5555);
        audio_backlog.push_back(16'hAAAA);
        repeat (8) audio_backlog.push_back(16'h7FFF);
        repeat (8) audio_backlog.push_back(16'h8000);
        queue_noise(150);
        wait_idle();

        // new words, burst starting on the alternate word
        write_reg(CFG_SLICE_THRESHOLD, CFG_DATA_W'($urandom_range(200, 2000)));
        write_reg(CFG_SAMPLE_PHASE, CFG_DATA_W'($urandom_range(4, 12)));
        word = random_biphase_word();
        write_reg(CFG_SYNC_NORMAL, word);
        do word = random_biphase_word(); while (word == sync_normal_reg);
        write_reg(CFG_SYNC_ALTERNATE, word);
        amp = $urandom_range(3000, 16000);
        queue_burst(word, 3, 2, amp, -amp, $urandom_range(0, 400));
        wait_idle();

        // top threshold, last reachable phase, equal extreme words, noise
        write_reg(CFG_SLICE_THRESHOLD, CFG_DATA_W'(15'h7FFF));
        write_reg(CFG_SAMPLE_PHASE, CFG_DATA_W'(HALF_BIT));
        write_reg(CFG_SYNC_NORMAL, 22'h3FFFFF);
        write_reg(CFG_SYNC_ALTERNATE, 22'h3FFFFF);
        queue_noise(60);
        wait_idle();

        // zero threshold and a phase the clock never reaches
        write_reg(CFG_SLICE_THRESHOLD, '0);
        write_reg(CFG_SAMPLE_PHASE, CFG_DATA_W'(5'd31));
        write_reg(CFG_SYNC_NORMAL, CFG_DATA_W'($urandom));
        write_reg(CFG_SYNC_ALTERNATE, CFG_DATA_W'($urandom));
        queue_noise(60);
        wait_idle();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
